// ----- sv/etfp_pkg.sv -----
// shared types and constants for the escape-time fractal pixel block
// no dependencies; imported by escape_time_fractal_pixel
`default_nettype none

package etfp_pkg;

    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;
    localparam int PIX_W  = 10;
    localparam int CNT_W  = 8;
    localparam int STEP_W = 62;
    localparam int THR_W  = 63;
    localparam int PART_W = 3;
    localparam int HALF_W = 32;

    // register index, paddr[5:3]
    localparam logic [2:0] REG_CORNER_RE = 3'd0;
    localparam logic [2:0] REG_CORNER_IM = 3'd1;
    localparam logic [2:0] REG_STEP      = 3'd2;
    localparam logic [2:0] REG_THR       = 3'd3;
    localparam logic [2:0] REG_LIMIT     = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_MUL  = 5'b00100,
        S_POST = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    // product currently running through the multiplier
    typedef enum logic [2:0] {
        J_CRE   = 3'd0,
        J_CIM   = 3'd1,
        J_SR    = 3'd2,
        J_SI    = 3'd3,
        J_CROSS = 3'd4
    } t_job;

endpackage

`default_nettype wire

// ----- sv/escape_time_fractal_pixel.sv -----
// escape-time fractal pixel evaluator, top level
// depends on etfp_pkg
`default_nettype none

// Takes one pixel word (column, row), forms c = corner + step * index in signed
// fixed point with FRAC_BITS fraction bits, and returns the escape count with the
// pixel indices echoed. All products go through one 32x32 multiplier: a 64x64
// product is an operand load, four partial products, a drain step and a post step.
// Setup and the first escape check take four products; each further iteration
// takes three.
// The input side stalls from acceptance until the result is handed to the output
// register, which holds one result while the next word is already taken.
module escape_time_fractal_pixel #(
    parameter int GRID_SIZE = 1024,
    parameter int FRAC_BITS = 60
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [etfp_pkg::PIX_W-1:0]   i_pixel_col,
    input  wire logic [etfp_pkg::PIX_W-1:0]   i_pixel_row,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [etfp_pkg::CNT_W-1:0]        o_escape_count,
    output logic [etfp_pkg::PIX_W-1:0]        o_out_col,
    output logic [etfp_pkg::PIX_W-1:0]        o_out_row,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [etfp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [etfp_pkg::DATA_W-1:0]  pwdata,
    output logic [etfp_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import etfp_pkg::*;

    localparam logic [DATA_W-1:0] FX_TWO    = 64'd1 << (FRAC_BITS + 1);
    localparam logic [DATA_W-1:0] FX_FOUR   = 64'd1 << (FRAC_BITS + 2);
    localparam logic [DATA_W-1:0] SIGN_MASK = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] SAT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] CORNER_RST = 64'd0 - FX_TWO;
    localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'(FX_FOUR / 64'(GRID_SIZE));
    localparam logic [THR_W-1:0]  THR_RST   = THR_W'(FX_TWO);
    localparam logic [CNT_W-1:0]  LIMIT_RST = 8'd255;
    localparam logic signed [DATA_W-1:0] FX_POS_TWO = FX_TWO;
    localparam logic signed [DATA_W-1:0] FX_NEG_TWO = 64'd0 - FX_TWO;

    function automatic logic [DATA_W-1:0] fx_mag(input logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (64'd0 - x) : x;
    endfunction

    // control state
    t_state              r_state, n_state;
    t_job                r_job, n_job;
    logic [PART_W-1:0]   r_part, n_part;
    logic                r_pvalid;
    logic                r_out_valid, n_out_valid;

    // configuration
    logic [DATA_W-1:0]   r_corner_re, r_corner_im;
    logic [STEP_W-1:0]   r_step;
    logic [THR_W-1:0]    r_thr;
    logic [DATA_W-1:0]   r_thr_eff;
    logic [CNT_W-1:0]    r_limit;

    // datapath
    logic [DATA_W-1:0]   r_opa, n_opa, r_opb, n_opb;
    logic [DATA_W-1:0]   r_prod, n_prod;
    logic [1:0]          r_pshift, n_pshift;
    logic [2*DATA_W-1:0] r_acc, n_acc;
    logic [PIX_W-1:0]    r_col, n_col, r_row, n_row;
    logic [DATA_W-1:0]   r_cre, n_cre, r_cim, n_cim;
    logic [DATA_W-1:0]   r_zr, n_zr, r_zi, n_zi;
    logic [DATA_W-1:0]   r_sr, n_sr, r_si, n_si;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]    r_hold, n_hold;
    logic [CNT_W-1:0]    r_res_count, n_res_count;
    logic [PIX_W-1:0]    r_res_col, n_res_col, r_res_row, n_res_row;

    logic                cfg_wr;
    logic [THR_W-1:0]    wr_thr;
    logic [DATA_W-1:0]   wr_thr_eff;
    logic                issue;
    logic [HALF_W-1:0]   a_half, b_half;
    logic [2*DATA_W-1:0] acc_add;
    logic [DATA_W-1:0]   prod_fx;
    logic [DATA_W-1:0]   corner_sel, coord_biased, coord;
    logic [DATA_W:0]     coord_sum;
    logic                coord_ovf;
    logic [DATA_W:0]     norm;
    logic                comp_big, escape;
    logic [CNT_W:0]      k_next;
    logic                at_limit;
    logic [DATA_W-1:0]   cross_dbl, cross_s, zr_new, zi_new;
    logic                out_free;

    // configuration port
    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign wr_thr     = pwdata[THR_W-1:0];
    assign wr_thr_eff = ({1'b0, wr_thr} > FX_FOUR) ? FX_FOUR : {1'b0, wr_thr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_re <= CORNER_RST;
            r_corner_im <= CORNER_RST;
            r_step      <= STEP_RST;
            r_thr       <= THR_RST;
            r_thr_eff   <= FX_TWO;
            r_limit     <= LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                REG_CORNER_RE: r_corner_re <= pwdata;
                REG_CORNER_IM: r_corner_im <= pwdata;
                REG_STEP:      r_step      <= pwdata[STEP_W-1:0];
                REG_THR: begin
                    r_thr     <= wr_thr;
                    r_thr_eff <= wr_thr_eff;
                end
                REG_LIMIT:     r_limit     <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_CORNER_RE: prdata = r_corner_re;
            REG_CORNER_IM: prdata = r_corner_im;
            REG_STEP:      prdata = {{(DATA_W-STEP_W){1'b0}}, r_step};
            REG_THR:       prdata = {{(DATA_W-THR_W){1'b0}}, r_thr};
            REG_LIMIT:     prdata = {{(DATA_W-CNT_W){1'b0}}, r_limit};
            default:       prdata = '0;
        endcase
    end

    // shared multiplier, one partial product a cycle while in the multiply state
    assign issue    = (r_state == S_MUL) && !r_part[2];
    assign a_half   = r_part[0] ? r_opa[DATA_W-1:HALF_W] : r_opa[HALF_W-1:0];
    assign b_half   = r_part[1] ? r_opb[DATA_W-1:HALF_W] : r_opb[HALF_W-1:0];
    assign n_prod   = {32'd0, a_half} * {32'd0, b_half};
    assign n_pshift = {1'b0, r_part[0]} + {1'b0, r_part[1]};

    always_comb begin
        case (r_pshift)
            2'd0:    acc_add = {64'd0, r_prod};
            2'd1:    acc_add = {32'd0, r_prod, 32'd0};
            2'd2:    acc_add = {r_prod, 64'd0};
            default: acc_add = '0;
        endcase
    end

    always_comb begin
        if (r_state == S_LOAD) begin
            n_acc = '0;
        end else if (r_pvalid) begin
            n_acc = r_acc + acc_add;
        end else begin
            n_acc = r_acc;
        end
    end

    assign prod_fx = r_acc[FRAC_BITS +: DATA_W];

    // grid coordinate with saturation
    assign corner_sel   = (r_job == J_CRE) ? r_corner_re : r_corner_im;
    assign coord_ovf    = |r_acc[2*DATA_W-1:DATA_W];
    assign coord_biased = corner_sel ^ SIGN_MASK;
    assign coord_sum    = {1'b0, coord_biased} + {1'b0, r_acc[DATA_W-1:0]};
    assign coord        = (coord_ovf || coord_sum[DATA_W]) ? SAT_MAX
                                                          : coord_sum[DATA_W-1:0] ^ SIGN_MASK;

    // escape test
    assign norm     = {1'b0, r_sr} + {1'b0, prod_fx};
    assign comp_big = ($signed(r_zr) > FX_POS_TWO) || ($signed(r_zr) < FX_NEG_TWO) ||
                      ($signed(r_zi) > FX_POS_TWO) || ($signed(r_zi) < FX_NEG_TWO);
    assign escape   = comp_big || (norm > {1'b0, r_thr_eff});
    assign k_next   = {1'b0, r_k} + 9'd1;
    assign at_limit = k_next >= {1'b0, r_limit};

    // iteration update
    assign cross_dbl = {prod_fx[DATA_W-2:0], 1'b0};
    assign cross_s   = (r_zr[DATA_W-1] ^ r_zi[DATA_W-1]) ? (64'd0 - cross_dbl) : cross_dbl;
    assign zi_new    = cross_s + r_cim;
    assign zr_new    = r_sr - r_si + r_cre;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_part      = r_part;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_col       = r_col;
        n_row       = r_row;
        n_cre       = r_cre;
        n_cim       = r_cim;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_sr        = r_sr;
        n_si        = r_si;
        n_k         = r_k;
        n_hold      = r_hold;
        n_res_count = r_res_count;
        n_res_col   = r_res_col;
        n_res_row   = r_res_row;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_col   = i_pixel_col;
                    n_row   = i_pixel_row;
                    n_job   = J_CRE;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_part  = '0;
                n_state = S_MUL;
                case (r_job)
                    J_CRE: begin
                        n_opa = {{(DATA_W-STEP_W){1'b0}}, r_step};
                        n_opb = {{(DATA_W-PIX_W){1'b0}}, r_col};
                    end
                    J_CIM: begin
                        n_opa = {{(DATA_W-STEP_W){1'b0}}, r_step};
                        n_opb = {{(DATA_W-PIX_W){1'b0}}, r_row};
                    end
                    J_SR: begin
                        n_opa = fx_mag(r_zr);
                        n_opb = fx_mag(r_zr);
                    end
                    J_SI: begin
                        n_opa = fx_mag(r_zi);
                        n_opb = fx_mag(r_zi);
                    end
                    J_CROSS: begin
                        n_opa = fx_mag(r_zr);
                        n_opb = fx_mag(r_zi);
                    end
                    default: begin
                        n_opa = '0;
                        n_opb = '0;
                    end
                endcase
            end
            S_MUL: begin
                n_part = r_part + 3'd1;
                if (r_part[2]) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_state = S_LOAD;
                case (r_job)
                    J_CRE: begin
                        n_cre = coord;
                        n_job = J_CIM;
                    end
                    J_CIM: begin
                        n_cim = coord;
                        n_zr  = r_cre;
                        n_zi  = coord;
                        n_k   = '0;
                        n_job = J_SR;
                    end
                    J_SR: begin
                        n_sr  = prod_fx;
                        n_job = J_SI;
                    end
                    J_SI: begin
                        n_si = prod_fx;
                        if (escape) begin
                            n_hold  = r_k;
                            n_state = S_HOLD;
                        end else if (at_limit) begin
                            n_hold  = r_limit;
                            n_state = S_HOLD;
                        end else begin
                            n_job = J_CROSS;
                        end
                    end
                    J_CROSS: begin
                        n_zr  = zr_new;
                        n_zi  = zi_new;
                        n_k   = k_next[CNT_W-1:0];
                        n_job = J_SR;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_HOLD: begin
                if (out_free) begin
                    n_res_count = r_hold;
                    n_res_col   = r_col;
                    n_res_row   = r_row;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= J_CRE;
            r_part      <= '0;
            r_pvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_part      <= n_part;
            r_pvalid    <= issue;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opa       <= n_opa;
        r_opb       <= n_opb;
        r_prod      <= n_prod;
        r_pshift    <= n_pshift;
        r_acc       <= n_acc;
        r_col       <= n_col;
        r_row       <= n_row;
        r_cre       <= n_cre;
        r_cim       <= n_cim;
        r_zr        <= n_zr;
        r_zi        <= n_zi;
        r_sr        <= n_sr;
        r_si        <= n_si;
        r_k         <= n_k;
        r_hold      <= n_hold;
        r_res_count <= n_res_count;
        r_res_col   <= n_res_col;
        r_res_row   <= n_res_row;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_escape_count = r_res_count;
    assign o_out_col      = r_res_col;
    assign o_out_row      = r_res_row;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after word accepted");

    a_accept_starts_coord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_LOAD && r_job == J_CRE))
        else $error("accepted word did not start coordinate product");

    a_result_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_HOLD))
        else $error("result word raised outside hold state");

    a_no_issue_outside_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvalid |-> $past(r_state == S_MUL))
        else $error("partial product without multiply state");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_escape_time_fractal_pixel.sv -----
// testbench for escape_time_fractal_pixel: directed table, then randomized views of the plane
// with a self-contained fixed-point escape-count predictor; needs etfp_pkg and the block
`timescale 1ns / 100ps

module tb_escape_time_fractal_pixel;
    import etfp_pkg::*;

    localparam int FRAC = 60;
    localparam int ITEMS = 1300;
    localparam int DRAIN_CYCLES = 6000;
    localparam logic [63:0] Q_TWO = 64'd1 << 61;
    localparam logic [63:0] Q_FOUR = 64'd1 << 62;
    localparam logic [63:0] SIGN_BIT = 64'd1 << 63;
    localparam logic [63:0] Q_MAX = SIGN_BIT - 64'd1;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PIXEL,
        ROW_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [2:0]       idx;
        logic [63:0]      value;
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic [CNT_W-1:0] count;
    } t_stim_row;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
    } t_pixel_result;

    typedef enum logic [1:0] {
        VIEW_NEAR,
        VIEW_NOISE,
        VIEW_DEEP
    } t_view;

    localparam int N_ROWS = 40;
    localparam t_stim_row DIRECTED_ROWS [0:N_ROWS-1] = '{
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd0, 10'd0, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd1023, 10'd1023, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd512, 10'd512, 8'd255},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd512, 10'd0, 8'd0},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd0, 10'd512, 8'd0},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd320, 10'd512, 8'd0},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd700, 10'd600, 8'd0},
        '{ROW_WRITE, REG_LIMIT, 64'd0, 10'd0, 10'd0, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd512, 10'd512, 8'd0},
        '{ROW_WRITE, REG_LIMIT, 64'd1, 10'd0, 10'd0, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd512, 10'd512, 8'd1},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd400, 10'd300, 8'd0},
        // threshold above 4.0 is capped
        '{ROW_WRITE, REG_THR, 64'h7FFF_FFFF_FFFF_FFFF, 10'd0, 10'd0, 8'd0},
        '{ROW_WRITE, REG_LIMIT, 64'd20, 10'd0, 10'd0, 8'd0},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd0, 10'd512, 8'd0},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd1023, 10'd512, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd0, 10'd0, 8'd0},
        '{ROW_WRITE, REG_THR, 64'd0, 10'd0, 10'd0, 8'd0},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd512, 10'd512, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd513, 10'd512, 8'd0},
        // zero step maps every pixel to the corner
        '{ROW_WRITE, REG_THR, Q_TWO, 10'd0, 10'd0, 8'd0},
        '{ROW_WRITE, REG_STEP, 64'd0, 10'd0, 10'd0, 8'd0},
        '{ROW_WRITE, REG_CORNER_RE, 64'd0, 10'd0, 10'd0, 8'd0},
        '{ROW_WRITE, REG_CORNER_IM, 64'd0, 10'd0, 10'd0, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd1023, 10'd1023, 8'd20},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd0, 10'd0, 8'd0},
        // step of 2.0, most negative corner, saturated coordinates
        '{ROW_WRITE, REG_STEP, Q_TWO, 10'd0, 10'd0, 8'd0},
        '{ROW_WRITE, REG_CORNER_RE, SIGN_BIT, 10'd0, 10'd0, 8'd0},
        '{ROW_WRITE, REG_CORNER_IM, SIGN_BIT, 10'd0, 10'd0, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd1023, 10'd1023, 8'd0},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd4, 10'd4, 8'd0},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd5, 10'd4, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd0, 10'd0, 8'd0},
        // carry out of the corner sum saturates
        '{ROW_WRITE, REG_STEP, 64'd1, 10'd0, 10'd0, 8'd0},
        '{ROW_WRITE, REG_CORNER_RE, Q_MAX, 10'd0, 10'd0, 8'd0},
        '{ROW_WRITE, REG_CORNER_IM, 64'd0, 10'd0, 10'd0, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd1, 10'd0, 8'd0},
        // one component just above 2.0
        '{ROW_WRITE, REG_CORNER_RE, Q_TWO + 64'd1, 10'd0, 10'd0, 8'd0},
        '{ROW_KNOWN, REG_LIMIT, 64'd0, 10'd0, 10'd0, 8'd0},
        '{ROW_PIXEL, REG_LIMIT, 64'd0, 10'd1023, 10'd1023, 8'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [PIX_W-1:0] i_pixel_col = '0;
    logic [PIX_W-1:0] i_pixel_row = '0;
    logic i_out_stall = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic o_in_stall;
    logic o_out_valid;
    logic [CNT_W-1:0] o_escape_count;
    logic [PIX_W-1:0] o_out_col;
    logic [PIX_W-1:0] o_out_row;
    logic [DATA_W-1:0] prdata;
    logic pready;

    logic [63:0] corner_re_q = 64'd0 - Q_TWO;
    logic [63:0] corner_im_q = 64'd0 - Q_TWO;
    logic [STEP_W-1:0] grid_step_q = STEP_W'(Q_FOUR >> 10);
    logic [THR_W-1:0] threshold_q = THR_W'(Q_TWO);
    logic [CNT_W-1:0] iter_limit_q = 8'd255;

    t_pixel_result expected_pixels[$];
    int mismatch_count = 0;
    int items_sent = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int rx_hold = 0;

    escape_time_fractal_pixel dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_escape_count (o_escape_count),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [63:0] magnitude(input logic [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    // product of two magnitudes, truncated to the fraction width
    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[FRAC+63:FRAC];
    endfunction

    function automatic logic [63:0] grid_coord(input logic [63:0] corner,
                                               input logic [STEP_W-1:0] stp,
                                               input logic [PIX_W-1:0] idx);
        logic [127:0] p;
        logic [64:0] s;
        p = 128'(stp) * 128'(idx);
        if (p[127:64] != 64'd0) return Q_MAX;
        s = {1'b0, corner ^ SIGN_BIT} + {1'b0, p[63:0]};
        if (s[64]) return Q_MAX;
        return s[63:0] ^ SIGN_BIT;
    endfunction

    function automatic bit escapes(input logic [63:0] re, input logic [63:0] im,
                                   input logic [63:0] thr);
        logic [63:0] ar;
        logic [63:0] ai;
        ar = magnitude(re);
        ai = magnitude(im);
        if (ar > Q_TWO || ai > Q_TWO) return 1'b1;
        return (fx_mul(ar, ar) + fx_mul(ai, ai)) > thr;
    endfunction

    function automatic logic [CNT_W-1:0] predict_escape(input logic [PIX_W-1:0] col,
                                                        input logic [PIX_W-1:0] row);
        logic [63:0] cre, cim, thr, zr, zi, ar, ai, sr, si, cross_dbl;
        logic [CNT_W-1:0] count;
        int k;
        cre = grid_coord(corner_re_q, grid_step_q, col);
        cim = grid_coord(corner_im_q, grid_step_q, row);
        thr = (64'(threshold_q) > Q_FOUR) ? Q_FOUR : 64'(threshold_q);
        if (escapes(cre, cim, thr)) return '0;
        zr = cre;
        zi = cim;
        count = iter_limit_q;
        for (k = 1; k < int'(iter_limit_q); k++) begin
            ar = magnitude(zr);
            ai = magnitude(zi);
            sr = fx_mul(ar, ar);
            si = fx_mul(ai, ai);
            cross_dbl = fx_mul(ar, ai) << 1;
            if (zr[63] != zi[63]) cross_dbl = 64'd0 - cross_dbl;
            zr = sr - si + cre;
            zi = cross_dbl + cim;
            if (escapes(zr, zi, thr)) begin
                count = CNT_W'(k);
                break;
            end
        end
        return count;
    endfunction

    // caller stands at a rising edge
    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
                              input bit known, input logic [CNT_W-1:0] known_count);
        int gap;
        t_pixel_result res;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_col <= col;
        i_pixel_row <= row;
        do @(posedge i_clk); while (o_in_stall);
        res.count = known ? known_count : predict_escape(col, row);
        res.col = col;
        res.row = row;
        expected_pixels.push_back(res);
        items_sent++;
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        wait (expected_pixels.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CORNER_RE: corner_re_q = value;
            REG_CORNER_IM: corner_im_q = value;
            REG_STEP:      grid_step_q = value[STEP_W-1:0];
            REG_THR:       threshold_q = value[THR_W-1:0];
            REG_LIMIT:     iter_limit_q = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_view(input t_view view);
        logic [63:0] cre, cim, stp, thr, lim;
        int e;
        if (view == VIEW_NOISE) begin
            cre = {$urandom, $urandom};
            cim = {$urandom, $urandom};
            stp = {$urandom, $urandom} >> $urandom_range(2, 63);
            thr = {$urandom, $urandom} >> $urandom_range(1, 8);
            lim = 64'($urandom_range(0, 255));
        end else begin
            cre = ({$urandom, $urandom} % (64'd3 << 60)) - (64'd5 << 59);
            cim = ({$urandom, $urandom} % (64'd5 << 59)) - (64'd3 << 59);
            e = $urandom_range(44, 52);
            stp = (64'd1 << e) | ({$urandom, $urandom} & ((64'd1 << e) - 64'd1));
            case ($urandom_range(0, 3))
                0: thr = Q_FOUR;
                1: thr = Q_TWO;
                2: thr = {$urandom, $urandom} % (Q_FOUR + 64'd1);
                default: thr = {$urandom, $urandom} >> 1;
            endcase
            lim = (view == VIEW_DEEP) ? 64'd255 : 64'($urandom_range(1, 32));
        end
        wait_drained();
        write_reg(REG_CORNER_RE, cre);
        write_reg(REG_CORNER_IM, cim);
        write_reg(REG_STEP, stp);
        write_reg(REG_THR, thr);
        write_reg(REG_LIMIT, lim);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected word: escape_count %0d out_col %0d out_row %0d",
                           o_escape_count, o_out_col, o_out_row);
                    mismatch_count++;
                end else begin
                    if (o_escape_count !== expected_pixels[0].count) begin
                        $error("escape_count expected %0d got %0d",
                               expected_pixels[0].count, o_escape_count);
                        mismatch_count++;
                    end
                    if (o_out_col !== expected_pixels[0].col) begin
                        $error("out_col expected %0d got %0d",
                               expected_pixels[0].col, o_out_col);
                        mismatch_count++;
                    end
                    if (o_out_row !== expected_pixels[0].row) begin
                        $error("out_row expected %0d got %0d",
                               expected_pixels[0].row, o_out_row);
                        mismatch_count++;
                    end
                    void'(expected_pixels.pop_front());
                end
                if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
                rx_hold = rx_burst ? 0 : $urandom_range(0, 12);
            end else if (o_out_valid && rx_hold > 0) begin
                rx_hold--;
            end
            i_out_stall <= (rx_hold > 0);
        end
    end

    initial begin
        #400_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int phase;
        int n;
        t_view view;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].value);
            end else begin
                send_pixel(DIRECTED_ROWS[r].col, DIRECTED_ROWS[r].row,
                           DIRECTED_ROWS[r].kind == ROW_KNOWN, DIRECTED_ROWS[r].count);
            end
        end

        phase = 0;
        while (items_sent < ITEMS) begin
            if (phase == 3) view = VIEW_DEEP;
            else if (phase % 4 == 1) view = VIEW_NOISE;
            else view = VIEW_NEAR;
            set_view(view);
            for (n = 0; n < ((view == VIEW_DEEP) ? 24 : 100); n++) begin
                send_pixel(PIX_W'($urandom), PIX_W'($urandom), 1'b0, '0);
                if ($urandom_range(0, 63) == 0) wait_drained();
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
